/* hw/rtl/ordered_list_append_remove_macros.svh */
// Assertion macros for the ordered list block.
// Used by the port checker; depends on nothing else.
`ifndef ORDERED_LIST_APPEND_REMOVE_MACROS_SVH
`define ORDERED_LIST_APPEND_REMOVE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define OLAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define OLAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/olar_pkg.sv */
// Shared types and constants of the ordered list block.
// Used by the cell, the top level and the checker; depends on nothing.
package olar_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_DUMP   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_MATCH,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0] key;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_DUMP  = 3'b100
    } state_t;

endpackage

/* hw/rtl/olar_cell.sv */
// One cell of the list chain: an entry, its occupied flag and a match flag.
// Depends on olar_pkg.
module olar_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  olar_pkg::cell_ctrl_t              ctrl,
    input  logic                              left_occ,
    input  logic                              left_hit,
    input  logic                              right_occ,
    input  logic signed [olar_pkg::DATA_W-1:0] right_data,
    input  logic signed [olar_pkg::DATA_W-1:0] head_data,
    output logic signed [olar_pkg::DATA_W-1:0] data,
    output logic                              occ,
    output logic                              hit_out
);

    logic signed [olar_pkg::DATA_W-1:0] data_reg, data_next;
    logic                               occ_reg, occ_next;
    logic                               match_reg, match_next;

    // A removal shifts this cell once any cell at or before it matched.
    assign hit_out = left_hit | match_reg;

    always_comb begin
        data_next  = data_reg;
        occ_next   = occ_reg;
        match_next = match_reg;
        unique case (ctrl.op)
            olar_pkg::CELL_APPEND: begin
                if (!occ_reg && left_occ) begin
                    data_next = ctrl.key;
                    occ_next  = 1'b1;
                end
            end
            olar_pkg::CELL_MATCH: begin
                match_next = occ_reg && (data_reg == ctrl.key);
            end
            olar_pkg::CELL_SHIFT: begin
                if (hit_out) begin
                    data_next = right_data;
                    occ_next  = right_occ;
                end
            end
            olar_pkg::CELL_ROTATE: begin
                if (occ_reg) begin
                    data_next = right_occ ? right_data : head_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule

/* hw/rtl/ordered_list_append_remove.sv */
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells, one entry
// per cell, with the head in cell 0. Append stores the value in the first free cell and
// answers in the cycle after the word is taken. Remove compares, then shifts: every
// cell compares its entry with the value as the word is accepted, and in the next cycle
// the first matching cell and all cells behind it load from their right neighbor,
// closing the gap. Dump rotates the occupied cells one step per cycle while the output
// register is free and shows the head each time, so a list of n entries gives n result
// words and is back in its original order at the end; an empty list gives one word with
// status empty. The cell chain is the only resource, so one input word is worked on at a
// time, and a word is taken only while the block is idle and the output register is free
// or being emptied. Every result word passes through one output register, and the
// status, entry and last flag of a word stay put while m_valid waits for m_ready. Cell
// contents need no reset; only state, m_valid, occupied flags and entry count are cleared.
// Depends on olar_pkg and olar_cell.
module ordered_list_append_remove (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_func,
    input  logic signed [olar_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic signed [olar_pkg::DATA_W-1:0] m_entry,
    output logic                               m_last
);

    olar_pkg::state_t                   state_reg, state_next;
    logic [olar_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [olar_pkg::CNT_W-1:0]         dump_reg, dump_next;

    logic                               m_valid_reg, m_valid_next;
    logic [1:0]                         m_status_reg, m_status_next;
    logic signed [olar_pkg::DATA_W-1:0] m_entry_reg, m_entry_next;
    logic                               m_last_reg, m_last_next;

    olar_pkg::cell_ctrl_t               ctrl;

    logic signed [olar_pkg::DATA_W-1:0] data_w [olar_pkg::DEPTH];
    logic                               occ_w  [olar_pkg::DEPTH];
    logic                               hit_w  [olar_pkg::DEPTH];

    logic out_free;
    logic accept;

    // The output register can take a new word when it is empty or being read.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == olar_pkg::ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // The cell chain: each cell looks at its left neighbor for the occupancy and
    // match-so-far flags, and at its right neighbor for the data it shifts in.
    for (genvar i = 0; i < olar_pkg::DEPTH; i++) begin : g_cell
        logic                               left_occ;
        logic                               left_hit;
        logic                               right_occ;
        logic signed [olar_pkg::DATA_W-1:0] right_data;

        if (i == 0) begin : g_head
            assign left_occ = 1'b1;
            assign left_hit = 1'b0;
        end else begin : g_body
            assign left_occ = occ_w[i-1];
            assign left_hit = hit_w[i-1];
        end

        if (i == olar_pkg::DEPTH - 1) begin : g_tail
            assign right_occ  = 1'b0;
            assign right_data = '0;
        end else begin : g_inner
            assign right_occ  = occ_w[i+1];
            assign right_data = data_w[i+1];
        end

        olar_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .left_occ   (left_occ),
            .left_hit   (left_hit),
            .right_occ  (right_occ),
            .right_data (right_data),
            .head_data  (data_w[0]),
            .data       (data_w[i]),
            .occ        (occ_w[i]),
            .hit_out    (hit_w[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_next     = dump_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_entry_next  = m_entry_reg;
        m_last_next   = m_last_reg;
        ctrl.op       = olar_pkg::CELL_HOLD;
        ctrl.key      = s_value;

        unique case (state_reg)
            olar_pkg::ST_IDLE: begin
                if (accept) begin
                    // Most operations answer at once with a single word.
                    m_valid_next  = 1'b1;
                    m_status_next = olar_pkg::STAT_OK;
                    m_entry_next  = '0;
                    m_last_next   = 1'b1;
                    unique case (olar_pkg::func_t'(s_func))
                        olar_pkg::FUNC_APPEND: begin
                            if (count_reg == olar_pkg::FULL_CNT) begin
                                m_status_next = olar_pkg::STAT_FULL;
                            end else begin
                                ctrl.op    = olar_pkg::CELL_APPEND;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        olar_pkg::FUNC_REMOVE: begin
                            if (count_reg == '0) begin
                                m_status_next = olar_pkg::STAT_EMPTY;
                            end else begin
                                // Compare now, answer after the shift.
                                ctrl.op      = olar_pkg::CELL_MATCH;
                                m_valid_next = 1'b0;
                                state_next   = olar_pkg::ST_SHIFT;
                            end
                        end
                        olar_pkg::FUNC_DUMP: begin
                            if (count_reg == '0) begin
                                m_status_next = olar_pkg::STAT_EMPTY;
                            end else begin
                                m_valid_next = 1'b0;
                                dump_next    = '0;
                                state_next   = olar_pkg::ST_DUMP;
                            end
                        end
                        olar_pkg::FUNC_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            olar_pkg::ST_SHIFT: begin
                if (out_free) begin
                    ctrl.op       = olar_pkg::CELL_SHIFT;
                    m_valid_next  = 1'b1;
                    m_entry_next  = '0;
                    m_last_next   = 1'b1;
                    state_next    = olar_pkg::ST_IDLE;
                    // The tail cell's flag is set when any cell matched.
                    if (hit_w[olar_pkg::DEPTH-1]) begin
                        m_status_next = olar_pkg::STAT_OK;
                        count_next    = count_reg - 1'b1;
                    end else begin
                        m_status_next = olar_pkg::STAT_NOTFOUND;
                    end
                end
            end
            olar_pkg::ST_DUMP: begin
                if (out_free) begin
                    ctrl.op       = olar_pkg::CELL_ROTATE;
                    m_valid_next  = 1'b1;
                    m_status_next = olar_pkg::STAT_OK;
                    m_entry_next  = data_w[0];
                    m_last_next   = (dump_reg + 1'b1) == count_reg;
                    dump_next     = dump_reg + 1'b1;
                    if ((dump_reg + 1'b1) == count_reg) begin
                        state_next = olar_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = olar_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olar_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_reg     <= dump_next;
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_entry  = m_entry_reg;
    assign m_last   = m_last_reg;

endmodule

/* hw/rtl/olar_checker.sv */
// Port-level checks of the ordered list block and their bind to the top level.
// Depends on ordered_list_append_remove_macros.svh and olar_pkg.
`include "ordered_list_append_remove_macros.svh"

module olar_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [1:0]                         m_status,
    input logic signed [olar_pkg::DATA_W-1:0] m_entry,
    input logic                               m_last
);

    // A word with a status other than ok is always the only word of its item.
    `OLAR_ASSERT_NOW(a_err_single,
        m_valid && (m_status != olar_pkg::STAT_OK),
        m_last && (m_entry == '0),
        "error status word must be last with zero entry")

    // While a dump is part way through, no new input word is taken.
    `OLAR_ASSERT_NOW(a_dump_blocks, m_valid && !m_last, !s_ready, "input taken during a dump")

    // A stalled result word holds.
    `OLAR_ASSERT_NEXT(a_out_hold,
        m_valid && !m_ready,
        m_valid && $stable({m_status, m_entry, m_last}),
        "result word changed while stalled")

endmodule

bind ordered_list_append_remove olar_checker u_olar_checker (.*);
